// ===== hdl/blr_pkg.sv =====
// Package for the Bresenham line rasterizer: widths, stream packing, queue item type.
// No dependencies; imported by every hdl module.
`default_nettype none

package blr_pkg;

    localparam int COORD_BITS  = 10;
    localparam int DEC_BITS    = COORD_BITS + 3;
    localparam int STR_BITS    = COORD_BITS + 2;
    localparam int S_TDATA_W   = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                       is_advance;
        logic                       swapped;
        coord_t                     major_pos;
        coord_t                     minor_pos;
        coord_t                     major_goal;
        logic                       major_neg;
        logic                       minor_neg;
        logic signed [DEC_BITS-1:0] decision;
        logic [STR_BITS-1:0]        straight_inc;
        logic signed [DEC_BITS-1:0] diagonal_inc;
    } blr_cmd_t;

    typedef struct packed {
        logic   pixel_valid;
        coord_t pixel_x;
        coord_t pixel_y;
        logic   last_pixel;
    } blr_pixel_t;

endpackage

`default_nettype wire

// ===== hdl/blr_front.sv =====
// Front end: unpacks an input item and, for a start, does the octant setup.
// Depends on blr_pkg.
`default_nettype none

module blr_front
    import blr_pkg::*;
(
    input  wire logic                 op,
    input  wire logic [S_TDATA_W-1:0] data,
    output blr_cmd_t                  cmd
);

    coord_t                       x0, y0, x1, y1;
    logic signed [COORD_BITS:0]   dx, dy;
    coord_t                       adx, ady, dmaj, dmin;
    logic                         swap;

    assign x0 = data[0*COORD_BITS +: COORD_BITS];
    assign y0 = data[1*COORD_BITS +: COORD_BITS];
    assign x1 = data[2*COORD_BITS +: COORD_BITS];
    assign y1 = data[3*COORD_BITS +: COORD_BITS];

    assign dx = $signed({1'b0, x1}) - $signed({1'b0, x0});
    assign dy = $signed({1'b0, y1}) - $signed({1'b0, y0});

    assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];

    assign swap = (adx < ady);
    assign dmaj = swap ? ady : adx;
    assign dmin = swap ? adx : ady;

    always_comb
    begin
        cmd.is_advance   = (op == OP_ADVANCE);
        cmd.swapped      = swap;
        cmd.major_pos    = swap ? y0 : x0;
        cmd.minor_pos    = swap ? x0 : y0;
        cmd.major_goal   = swap ? y1 : x1;
        cmd.major_neg    = swap ? dy[COORD_BITS] : dx[COORD_BITS];
        cmd.minor_neg    = swap ? dx[COORD_BITS] : dy[COORD_BITS];
        cmd.decision     = $signed({2'b00, dmin, 1'b0}) - $signed({3'b000, dmaj});
        cmd.straight_inc = {1'b0, dmin, 1'b0};
        cmd.diagonal_inc = $signed({2'b00, dmin, 1'b0}) - $signed({2'b00, dmaj, 1'b0});
    end

endmodule

`default_nettype wire

// ===== hdl/blr_queue.sv =====
// Short register queue between front and back; push and pop can happen in the same cycle.
// Depends on blr_pkg.
`default_nettype none

module blr_queue
    import blr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  blr_cmd_t      push_cmd,
    output logic          not_full,
    input  wire logic     pop,
    output logic          not_empty,
    output blr_cmd_t      pop_cmd
);

    blr_cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]    count_reg, count_next;
    logic                 do_push, do_pop;

    assign not_full  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/blr_back.sv =====
// Back end: line state, one Bresenham step per advance item, registered pixel output.
// Depends on blr_pkg.
`default_nettype none

module blr_back
    import blr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cmd_valid,
    input  blr_cmd_t   cmd,
    output logic       cmd_take,
    output logic       out_valid,
    input  wire logic  out_ready,
    output blr_pixel_t out_pixel
);

    logic                       active_reg, active_next;
    logic                       swapped_reg, swapped_next;
    coord_t                     major_reg, major_next;
    coord_t                     minor_reg, minor_next;
    coord_t                     goal_reg, goal_next;
    logic                       major_neg_reg, major_neg_next;
    logic                       minor_neg_reg, minor_neg_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;
    logic [STR_BITS-1:0]        str_reg, str_next;
    logic signed [DEC_BITS-1:0] diag_reg, diag_next;
    logic                       out_valid_reg;
    blr_pixel_t                 pix_reg, pix_next;
    logic                       last;

    assign cmd_take  = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_pixel = pix_reg;

    always_comb
    begin
        active_next    = active_reg;
        swapped_next   = swapped_reg;
        major_next     = major_reg;
        minor_next     = minor_reg;
        goal_next      = goal_reg;
        major_neg_next = major_neg_reg;
        minor_neg_next = minor_neg_reg;
        dec_next       = dec_reg;
        str_next       = str_reg;
        diag_next      = diag_reg;
        pix_next       = '0;
        last           = 1'b0;
        if (!cmd.is_advance)
        begin
            swapped_next   = cmd.swapped;
            major_next     = cmd.major_pos;
            minor_next     = cmd.minor_pos;
            goal_next      = cmd.major_goal;
            major_neg_next = cmd.major_neg;
            minor_neg_next = cmd.minor_neg;
            dec_next       = cmd.decision;
            str_next       = cmd.straight_inc;
            diag_next      = cmd.diagonal_inc;
        end
        else if (active_reg)
        begin
            if (dec_reg <= 0)
            begin
                dec_next = dec_reg + $signed({1'b0, str_reg});
            end
            else
            begin
                dec_next   = dec_reg + diag_reg;
                minor_next = minor_neg_reg ? minor_reg - 1'b1 : minor_reg + 1'b1;
            end
            major_next = major_neg_reg ? major_reg - 1'b1 : major_reg + 1'b1;
        end
        if (!cmd.is_advance || active_reg)
        begin
            last                 = (major_next == goal_next);
            active_next          = !last;
            pix_next.pixel_valid = 1'b1;
            pix_next.pixel_x     = swapped_next ? minor_next : major_next;
            pix_next.pixel_y     = swapped_next ? major_next : minor_next;
            pix_next.last_pixel  = last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            swapped_reg   <= 1'b0;
            major_reg     <= '0;
            minor_reg     <= '0;
            goal_reg      <= '0;
            major_neg_reg <= 1'b0;
            minor_neg_reg <= 1'b0;
            dec_reg       <= '0;
            str_reg       <= '0;
            diag_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                active_reg    <= active_next;
                swapped_reg   <= swapped_next;
                major_reg     <= major_next;
                minor_reg     <= minor_next;
                goal_reg      <= goal_next;
                major_neg_reg <= major_neg_next;
                minor_neg_reg <= minor_neg_next;
                dec_reg       <= dec_next;
                str_reg       <= str_next;
                diag_reg      <= diag_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            pix_reg <= pix_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bresenham_line_rasterizer_top.sv =====
// Top level of the Bresenham line rasterizer: front setup, item queue, stepping back end.
// Depends on blr_pkg, blr_front, blr_queue, blr_back.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser = op; tdata = endpoints
//  m_axis    out  m_axis_tvalid / m_axis_tready   tuser = pixel_valid; tdata = pixel; tlast
//
// One item per cycle sustained while m_axis_tready stays high. With the queue empty, an item
// taken on s_axis is written into the queue, then taken by the back end into its pixel register.
// The rate is set by the back end, which updates the line state registers once per item taken.
// Reset clears the line state to idle; no clearing pass.
// While a result waits on m_axis_tready the two-entry queue takes up to two more items,
// then s_axis_tready drops until the back end moves again.
`default_nettype none

module bresenham_line_rasterizer_top
    import blr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,  // x_start, y_start, x_end, y_end
    input  wire logic                 s_axis_tuser,  // op
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0]      m_axis_tdata,  // pixel_x, pixel_y
    output logic                      m_axis_tuser,  // pixel_valid
    output logic                      m_axis_tlast   // last_pixel
);

    blr_cmd_t   front_cmd, queue_cmd;
    logic       queue_not_empty, queue_pop;
    blr_pixel_t pixel;

    blr_front u_front
    (
        .op   (s_axis_tuser),
        .data (s_axis_tdata),
        .cmd  (front_cmd)
    );

    blr_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_cmd  (front_cmd),
        .not_full  (s_axis_tready),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_cmd   (queue_cmd)
    );

    blr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (queue_cmd),
        .cmd_take  (queue_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pixel (pixel)
    );

    assign m_axis_tdata = M_TDATA_W'({pixel.pixel_y, pixel.pixel_x});
    assign m_axis_tuser = pixel.pixel_valid;
    assign m_axis_tlast = pixel.last_pixel;

endmodule

`default_nettype wire

// ===== hdl/blr_checker.sv =====
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on blr_pkg and bresenham_line_rasterizer_top.
`default_nettype none

module blr_checker
    import blr_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                 s_axis_tuser,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tuser,
    input wire logic                 m_axis_tlast
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input item withdrawn or changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item dropped or changed while stalled");

    a_last_is_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last flag on an item with no pixel");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0 && !m_axis_tlast)
        else $error("idle advance item carries nonzero payload");

    a_ready_low_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input closed without an output stall");

endmodule

bind bresenham_line_rasterizer_top blr_checker u_blr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/blr_pixel_checker.sv =====
// Checker for the Bresenham line rasterizer: watches both stream channels, predicts each pixel.
// Depends on blr_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps

module blr_pixel_checker
    import blr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast,
    output int                        fail_count,
    output int                        pixels_owed
);

    logic                       line_on;
    logic                       swapped;
    coord_t                     maj_pos;
    coord_t                     min_pos;
    coord_t                     maj_goal;
    logic                       maj_neg;
    logic                       min_neg;
    logic signed [DEC_BITS-1:0] decision;
    logic [STR_BITS-1:0]        straight_inc;
    logic signed [DEC_BITS-1:0] diagonal_inc;

    blr_pixel_t pixel_q[$];
    blr_pixel_t got;
    blr_pixel_t want;

    task automatic report_mismatch(input string what);
        $display("%0t blr_pixel_checker: %s", $realtime, what);
        fail_count++;
    endtask

    // advances the line state by one item and returns the pixel it yields
    function automatic blr_pixel_t rasterize(input logic op, input logic [S_TDATA_W-1:0] data);
        int         x0, y0, x1, y1;
        int         dx, dy, adx, ady, dmaj, dmin;
        blr_pixel_t px;
        px = '0;
        if (op == OP_START)
        begin
            x0 = int'(data[0*COORD_BITS +: COORD_BITS]);
            y0 = int'(data[1*COORD_BITS +: COORD_BITS]);
            x1 = int'(data[2*COORD_BITS +: COORD_BITS]);
            y1 = int'(data[3*COORD_BITS +: COORD_BITS]);
            dx = x1 - x0;
            dy = y1 - y0;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            swapped = (adx < ady);
            if (swapped)
            begin
                maj_pos = coord_t'(y0);
                min_pos = coord_t'(x0);
                maj_goal = coord_t'(y1);
                maj_neg = (dy < 0);
                min_neg = (dx < 0);
                dmaj = ady;
                dmin = adx;
            end
            else
            begin
                maj_pos = coord_t'(x0);
                min_pos = coord_t'(y0);
                maj_goal = coord_t'(x1);
                maj_neg = (dx < 0);
                min_neg = (dy < 0);
                dmaj = adx;
                dmin = ady;
            end
            decision = DEC_BITS'(2 * dmin - dmaj);
            straight_inc = STR_BITS'(2 * dmin);
            diagonal_inc = DEC_BITS'(2 * dmin - 2 * dmaj);
        end
        else if (!line_on)
        begin
            return px;
        end
        else
        begin
            if (decision <= 0)
            begin
                decision = DEC_BITS'(int'(decision) + int'(straight_inc));
            end
            else
            begin
                decision = DEC_BITS'(int'(decision) + int'(diagonal_inc));
                min_pos = min_neg ? min_pos - 1'b1 : min_pos + 1'b1;
            end
            maj_pos = maj_neg ? maj_pos - 1'b1 : maj_pos + 1'b1;
        end
        px.pixel_valid = 1'b1;
        px.pixel_x = swapped ? min_pos : maj_pos;
        px.pixel_y = swapped ? maj_pos : min_pos;
        px.last_pixel = (maj_pos == maj_goal);
        line_on = !px.last_pixel;
        return px;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            line_on = 1'b0;
            swapped = 1'b0;
            maj_pos = '0;
            min_pos = '0;
            maj_goal = '0;
            maj_neg = 1'b0;
            min_neg = 1'b0;
            decision = '0;
            straight_inc = '0;
            diagonal_inc = '0;
            pixel_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                pixel_q.insert(pixel_q.size(), rasterize(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got.pixel_valid = m_tuser;
                got.pixel_x = m_tdata[0 +: COORD_BITS];
                got.pixel_y = m_tdata[COORD_BITS +: COORD_BITS];
                got.last_pixel = m_tlast;
                if (m_tdata[M_TDATA_W-1:2*COORD_BITS] != '0)
                begin
                    report_mismatch($sformatf("tdata padding not zero: %h", m_tdata));
                end
                if (pixel_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel item %p", got));
                end
                else
                begin
                    want = pixel_q[0];
                    pixel_q.delete(0);
                    if (got.pixel_valid !== want.pixel_valid)
                    begin
                        report_mismatch($sformatf("pixel_valid got %b want %b",
                                                  got.pixel_valid, want.pixel_valid));
                    end
                    if (got.pixel_x !== want.pixel_x)
                    begin
                        report_mismatch($sformatf("pixel_x got %0d want %0d",
                                                  got.pixel_x, want.pixel_x));
                    end
                    if (got.pixel_y !== want.pixel_y)
                    begin
                        report_mismatch($sformatf("pixel_y got %0d want %0d",
                                                  got.pixel_y, want.pixel_y));
                    end
                    if (got.last_pixel !== want.last_pixel)
                    begin
                        report_mismatch($sformatf("last_pixel got %b want %b",
                                                  got.last_pixel, want.last_pixel));
                    end
                end
            end
        end
        pixels_owed = pixel_q.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top for the Bresenham line rasterizer: clock, reset, line stimulus, verdict.
// Depends on blr_pkg, bresenham_line_rasterizer_top and blr_pixel_checker.
`timescale 1ns / 1ps

module tb_top
    import blr_pkg::*;
();

    localparam int     MAX_CYCLES   = 400000;
    localparam int     RANDOM_ITEMS = 650;
    localparam int     COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam coord_t CORNER       = coord_t'(COORD_MAX);

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_STARVED} rx_mode_e;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;

    int       fail_count;
    int       pixels_owed;
    int       cycle_count = 0;
    int       burst_left;
    rx_mode_e rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_phase = 0;

    always #4 clk = ~clk;

    bresenham_line_rasterizer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    blr_pixel_checker pixel_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .s_tuser     (s_axis_tuser),
        .m_tvalid    (m_axis_tvalid),
        .m_tready    (m_axis_tready),
        .m_tdata     (m_axis_tdata),
        .m_tuser     (m_axis_tuser),
        .m_tlast     (m_axis_tlast),
        .fail_count  (fail_count),
        .pixels_owed (pixels_owed)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver back-pressure, switching between patterns
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_e'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        rx_phase = (rx_phase + 1) % 5;
        case (rx_mode)
            RX_OPEN:     m_axis_tready <= 1'b1;
            RX_RANDOM:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: m_axis_tready <= (rx_phase == 0);
            default:     m_axis_tready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    // called at a falling edge; returns at a falling edge with no drive made there
    task automatic send_item(input logic op, input logic [S_TDATA_W-1:0] data);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= data;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        burst_left--;
        if (burst_left <= 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 4) == 0 ? $urandom_range(8, 20) : $urandom_range(1, 4))
                @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
        end
    endtask

    task automatic start_line(input coord_t xs, input coord_t ys, input coord_t xe,
                              input coord_t ye);
        send_item(OP_START, S_TDATA_W'({ye, xe, ys, xs}));
    endtask

    task automatic advance(input int n);
        repeat (n) send_item(OP_ADVANCE, S_TDATA_W'({$urandom, $urandom}));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pixels_owed != 0) @(negedge clk);
    endtask

    function automatic coord_t near_coord(input coord_t base, input int reach);
        int v;
        int off;
        off = $urandom_range(0, 2 * reach);
        v = int'(base) + off - reach;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return coord_t'(v);
    endfunction

    function automatic int line_span(input coord_t xs, input coord_t ys, input coord_t xe,
                                     input coord_t ye);
        int dx;
        int dy;
        dx = int'(xe) - int'(xs);
        dy = int'(ye) - int'(ys);
        dx = (dx < 0) ? -dx : dx;
        dy = (dy < 0) ? -dy : dy;
        return (dx > dy) ? dx : dy;
    endfunction

    initial
    begin
        int     sent;
        int     next_drain;
        int     pick;
        int     span;
        int     reach;
        coord_t xs, ys, xe, ye;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = OP_START;
        s_axis_tdata = '0;
        burst_left = $urandom_range(1, 6);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // advance while idle, all data bits set
        send_item(OP_ADVANCE, '1);
        // single point line at the far corner, then idle
        start_line(CORNER, CORNER, CORNER, CORNER);
        advance(1);
        // shallow line, then one advance past its end
        start_line(0, 0, 3, 1);
        advance(4);
        // steep line, both steps negative
        start_line(5, 6, 3, 2);
        advance(4);
        // 45 degree tie keeps x as major axis
        start_line(10, 10, 7, 13);
        advance(3);
        // full-range diagonal, dropped by a new start
        start_line(0, CORNER, CORNER, 0);
        advance(2);
        start_line(CORNER, 0, 0, CORNER);
        advance(1);
        drain_results();

        sent = 0;
        next_drain = 200;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            reach = ($urandom_range(0, 5) == 0) ? 40 : 8;
            xs = coord_t'($urandom);
            ys = coord_t'($urandom);
            xe = near_coord(xs, reach);
            ye = near_coord(ys, reach);
            if (pick < 70)
            begin
                span = line_span(xs, ys, xe, ye);
                start_line(xs, ys, xe, ye);
                advance(span);
                sent += 1 + span;
                if ($urandom_range(0, 3) == 0)
                begin
                    advance(1);
                end
            end
            else if (pick < 85)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    xe = coord_t'($urandom);
                    ye = coord_t'($urandom);
                end
                span = line_span(xs, ys, xe, ye);
                span = (span == 0) ? 0 : $urandom_range(0, (span - 1 < 20) ? span - 1 : 20);
                start_line(xs, ys, xe, ye);
                advance(span);
                sent += 1 + span;
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_item(logic'($urandom_range(0, 1)), S_TDATA_W'({$urandom, $urandom}));
                    sent++;
                end
            end
            if (sent >= next_drain)
            begin
                drain_results();
                next_drain += 200;
            end
        end

        drain_results();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
